### sv/dopq_pkg.sv
// Shared types and constants for the deadline ordered priority queue.
package dopq_pkg;

    localparam int DEPTH_DEF = 16;

    // One stored entry: tag, deadline date and effort level.
    typedef struct packed {
        logic [15:0] tag;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [1:0]  effort;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Command codes of one request.
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_LIST   = 1'b1
    } cmd_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_LISTED   = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CHECK,
        S_INS_CMP,
        S_LST_RD,
        S_LST_OUT
    } seq_state_t;

endpackage

### sv/dopq_ram.sv
// Generic simple dual port RAM with registered read.
module dopq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/dopq_key_cmp.sv
// Priority key comparator: earlier date first, higher effort on an equal date.
module dopq_key_cmp (
    input  dopq_pkg::entry_t a,
    input  dopq_pkg::entry_t b,
    output logic             a_ahead
);

    import dopq_pkg::*;

    logic [20:0] date_a;
    logic [20:0] date_b;

    // Compare year, month and day as one concatenated key
    assign date_a  = {a.year, a.month, a.day};
    assign date_b  = {b.year, b.month, b.day};
    assign a_ahead = (date_a < date_b) || ((date_a == date_b) && (a.effort > b.effort));

endmodule

### sv/deadline_ordered_priority_queue_unit.sv
// Top level of the deadline ordered priority queue: sequencer, entry RAM and comparator.
//
// A request is taken when start is high and busy is low. An insert walks the
// stored entries from the tail, reading one entry, comparing it with the new
// key in the single comparator and moving it up one place; each entry that
// moves takes a RAM read, then a compare and write. A dropped insert and a
// list of an empty queue each give one result without touching the RAM. A list
// reads the RAM one entry at a time and puts out one result per entry. Each
// result appears on the result ports for exactly one cycle with out_valid high
// and cannot be held off, so the receiver must take every result the cycle it
// shows. The queue starts empty after reset and needs no clearing pass.
module deadline_ordered_priority_queue_unit #(
    parameter int DEPTH = dopq_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [15:0] task_tag,
    input  logic [11:0] due_year,
    input  logic [3:0]  due_month,
    input  logic [4:0]  due_day,
    input  logic [1:0]  effort,
    output logic        out_valid,
    output logic [1:0]  status,
    output logic [15:0] out_tag,
    output logic [11:0] out_year,
    output logic [3:0]  out_month,
    output logic [4:0]  out_day,
    output logic [1:0]  out_effort,
    output logic        last
);

    import dopq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    seq_state_t     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  idx_reg, idx_next;
    entry_t         new_reg, new_next;
    logic           out_valid_reg, out_valid_next;
    status_t        status_reg, status_next;
    entry_t         out_entry_reg, out_entry_next;
    logic           last_reg, last_next;

    logic           ram_wr_en;
    logic [AW-1:0]  ram_wr_addr;
    entry_t         ram_wr_data;
    logic [AW-1:0]  ram_rd_addr;
    entry_t         ram_rd_data;
    logic           new_ahead;
    logic [CW-1:0]  idx_dec;
    logic [CW-1:0]  idx_inc;
    entry_t         in_entry;

    assign in_entry = '{tag: task_tag, year: due_year, month: due_month,
                        day: due_day, effort: effort};
    assign idx_dec  = idx_reg - CW'(1);
    assign idx_inc  = idx_reg + CW'(1);

    dopq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    dopq_key_cmp u_cmp (
        .a       (new_reg),
        .b       (ram_rd_data),
        .a_ahead (new_ahead)
    );

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold working and result payload
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        new_reg       <= new_next;
        status_reg    <= status_next;
        out_entry_reg <= out_entry_next;
        last_reg      <= last_next;
    end

    // Sequence inserts and lists
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        new_next       = new_reg;
        out_valid_next = 1'b0;
        status_next    = status_reg;
        out_entry_next = out_entry_reg;
        last_next      = last_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = idx_reg[AW-1:0];
        ram_wr_data    = new_reg;
        ram_rd_addr    = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd_t'(command) == CMD_INSERT)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            // Drop the request on a full queue
                            out_valid_next = 1'b1;
                            status_next    = ST_DROPPED;
                            out_entry_next = '0;
                            last_next      = 1'b1;
                        end
                        else
                        begin
                            new_next   = in_entry;
                            idx_next   = count_reg;
                            state_next = S_INS_CHECK;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_EMPTY;
                        out_entry_next = '0;
                        last_next      = 1'b1;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_LST_RD;
                    end
                end
            end

            S_INS_CHECK:
            begin
                if (idx_reg == '0)
                begin
                    // Reached the head: place the new entry there
                    ram_wr_en      = 1'b1;
                    count_next     = count_reg + CW'(1);
                    out_valid_next = 1'b1;
                    status_next    = ST_INSERTED;
                    out_entry_next = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    ram_rd_addr = idx_dec[AW-1:0];
                    state_next  = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                ram_wr_en = 1'b1;
                if (new_ahead)
                begin
                    // Shift the predecessor up one place and keep walking
                    ram_wr_data = ram_rd_data;
                    idx_next    = idx_dec;
                    state_next  = S_INS_CHECK;
                end
                else
                begin
                    count_next     = count_reg + CW'(1);
                    out_valid_next = 1'b1;
                    status_next    = ST_INSERTED;
                    out_entry_next = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_LST_RD:
            begin
                state_next = S_LST_OUT;
            end

            S_LST_OUT:
            begin
                out_valid_next = 1'b1;
                status_next    = ST_LISTED;
                out_entry_next = ram_rd_data;
                last_next      = (idx_inc == count_reg);
                idx_next       = idx_inc;
                state_next     = (idx_inc == count_reg) ? S_IDLE : S_LST_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign out_tag    = out_entry_reg.tag;
    assign out_year   = out_entry_reg.year;
    assign out_month  = out_entry_reg.month;
    assign out_day    = out_entry_reg.day;
    assign out_effort = out_entry_reg.effort;
    assign last       = last_reg;

endmodule

### tb/dopq_order_checker.sv
// Result checker for the deadline ordered priority queue: tracks queue contents and compares.
module dopq_order_checker #(
    parameter int DEPTH = dopq_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        command,
    input  logic [15:0] task_tag,
    input  logic [11:0] due_year,
    input  logic [3:0]  due_month,
    input  logic [4:0]  due_day,
    input  logic [1:0]  effort,
    input  logic        out_valid,
    input  logic [1:0]  status,
    input  logic [15:0] out_tag,
    input  logic [11:0] out_year,
    input  logic [3:0]  out_month,
    input  logic [4:0]  out_day,
    input  logic [1:0]  out_effort,
    input  logic        last,
    output int          fail_count,
    output int          pending
);

    import dopq_pkg::*;

    // One result as the block should show it.
    typedef struct packed {
        status_t     status;
        logic [15:0] tag;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [1:0]  effort;
        logic        last;
    } queue_result_t;

    entry_t        sorted_entries[$];
    queue_result_t awaited_results[$];

    // True when a sorts strictly ahead of b: earlier date, then higher effort.
    function automatic logic sorts_ahead(entry_t a, entry_t b);
        if (a.year != b.year)
            return a.year < b.year;
        if (a.month != b.month)
            return a.month < b.month;
        if (a.day != b.day)
            return a.day < b.day;
        return a.effort > b.effort;
    endfunction

    // Apply one request to the tracked queue and queue up the results it causes.
    function automatic void apply_request(cmd_t cmd, entry_t e);
        queue_result_t r;
        int            pos;
        logic          found;
        r = '0;
        if (cmd == CMD_INSERT)
        begin
            r.last = 1'b1;
            if (sorted_entries.size() >= DEPTH)
            begin
                r.status = ST_DROPPED;
            end
            else
            begin
                // place after every entry with an equal key
                pos = sorted_entries.size();
                found = 1'b0;
                for (int i = 0; i < sorted_entries.size() && !found; i++)
                begin
                    if (sorts_ahead(e, sorted_entries[i]))
                    begin
                        pos = i;
                        found = 1'b1;
                    end
                end
                sorted_entries.insert(pos, e);
                r.status = ST_INSERTED;
            end
            awaited_results.push_back(r);
        end
        else if (sorted_entries.size() == 0)
        begin
            r.status = ST_EMPTY;
            r.last = 1'b1;
            awaited_results.push_back(r);
        end
        else
        begin
            foreach (sorted_entries[i])
            begin
                r.status = ST_LISTED;
                r.tag    = sorted_entries[i].tag;
                r.year   = sorted_entries[i].year;
                r.month  = sorted_entries[i].month;
                r.day    = sorted_entries[i].day;
                r.effort = sorted_entries[i].effort;
                r.last   = (i == sorted_entries.size() - 1);
                awaited_results.push_back(r);
            end
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s expected 0x%0h got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare the result on the ports with the oldest awaited one.
    function automatic void check_result();
        queue_result_t want;
        if (awaited_results.size() == 0)
        begin
            $error("unexpected result: status %0d tag 0x%0h", status, out_tag);
            fail_count++;
        end
        else
        begin
            want = awaited_results.pop_front();
            check_field("status", want.status, status);
            check_field("out_tag", want.tag, out_tag);
            check_field("out_year", want.year, out_year);
            check_field("out_month", want.month, out_month);
            check_field("out_day", want.day, out_day);
            check_field("out_effort", want.effort, out_effort);
            check_field("last", want.last, last);
        end
    endfunction

    // Take results first, then any request accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sorted_entries.delete();
            awaited_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid)
                check_result();
            if (start && !busy)
                apply_request(cmd_t'(command),
                              '{tag: task_tag, year: due_year, month: due_month,
                                day: due_day, effort: effort});
        end
        pending = awaited_results.size();
    end

endmodule

### tb/tb.sv
// Testbench top for the deadline ordered priority queue: clock, reset, requests and verdict.
module tb;
    import dopq_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        command = CMD_INSERT;
    logic [15:0] task_tag = '0;
    logic [11:0] due_year = '0;
    logic [3:0]  due_month = '0;
    logic [4:0]  due_day = '0;
    logic [1:0]  effort = '0;

    logic        busy;
    logic        out_valid;
    logic [1:0]  status;
    logic [15:0] out_tag;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [1:0]  out_effort;
    logic        last;

    int fail_count;
    int pending;
    int inserts_sent = 0;
    bit gaps_on = 1'b1;

    always #1 clk = ~clk;

    deadline_ordered_priority_queue_unit #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .task_tag(task_tag),
        .due_year(due_year),
        .due_month(due_month),
        .due_day(due_day),
        .effort(effort),
        .out_valid(out_valid),
        .status(status),
        .out_tag(out_tag),
        .out_year(out_year),
        .out_month(out_month),
        .out_day(out_day),
        .out_effort(out_effort),
        .last(last)
    );

    dopq_order_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .task_tag(task_tag),
        .due_year(due_year),
        .due_month(due_month),
        .due_day(due_day),
        .effort(effort),
        .out_valid(out_valid),
        .status(status),
        .out_tag(out_tag),
        .out_year(out_year),
        .out_month(out_month),
        .out_day(out_day),
        .out_effort(out_effort),
        .last(last),
        .fail_count(fail_count),
        .pending(pending)
    );

    // Present one request at a falling edge and hold it until the block takes it.
    task automatic send_request(cmd_t cmd, entry_t e);
        while (gaps_on && $urandom_range(0, 99) < 37)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start     <= 1'b1;
        command   <= cmd;
        task_tag  <= e.tag;
        due_year  <= e.year;
        due_month <= e.month;
        due_day   <= e.day;
        effort    <= e.effort;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        if (cmd == CMD_INSERT)
            inserts_sent++;
    endtask

    // Random entry: mostly plausible dates, a cluster around one date for ties.
    function automatic entry_t random_entry();
        entry_t e;
        e.tag = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 3))
            0:
            begin
                e.year  = 12'($urandom_range(0, 4095));
                e.month = 4'($urandom_range(0, 15));
                e.day   = 5'($urandom_range(0, 31));
            end
            1:
            begin
                e.year  = 12'd2025;
                e.month = 4'd6;
                e.day   = 5'($urandom_range(14, 16));
            end
            default:
            begin
                e.year  = 12'($urandom_range(2024, 2026));
                e.month = 4'($urandom_range(1, 12));
                e.day   = 5'($urandom_range(1, 31));
            end
        endcase
        e.effort = 2'($urandom_range(0, 3));
        return e;
    endfunction

    initial
    begin
        int settle;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty list, ties, extremes of each field, then a full list
        send_request(CMD_LIST, random_entry());
        send_request(CMD_INSERT, '{16'h1234, 12'd2025, 4'd6, 5'd15, 2'd2});
        send_request(CMD_INSERT, '{16'h1235, 12'd2025, 4'd6, 5'd15, 2'd2});
        send_request(CMD_INSERT, '{16'h1236, 12'd2025, 4'd6, 5'd15, 2'd3});
        send_request(CMD_INSERT, '{16'h1237, 12'd2025, 4'd6, 5'd15, 2'd1});
        send_request(CMD_INSERT, '{16'h0000, 12'd0, 4'd0, 5'd0, 2'd0});
        send_request(CMD_INSERT, '{16'hffff, 12'd4095, 4'd15, 5'd31, 2'd3});
        send_request(CMD_INSERT, '{16'h2001, 12'd2025, 4'd6, 5'd14, 2'd0});
        send_request(CMD_INSERT, '{16'h2002, 12'd2025, 4'd5, 5'd31, 2'd3});
        send_request(CMD_INSERT, '{16'h2003, 12'd2024, 4'd12, 5'd31, 2'd3});
        send_request(CMD_LIST, '{16'hffff, 12'd4095, 4'd15, 5'd31, 2'd3});

        // Random mix of inserts and lists, one stretch without gaps
        for (int n = 0; n < 88; n++)
        begin
            gaps_on = !(n >= 30 && n < 60);
            if ($urandom_range(0, 99) < 35)
                send_request(CMD_INSERT, random_entry());
            else
                send_request(CMD_LIST, random_entry());
        end

        // Make sure the queue fills and one insert is dropped, then list it all
        gaps_on = 1'b1;
        while (inserts_sent <= DEPTH)
            send_request(CMD_INSERT, random_entry());
        send_request(CMD_LIST, random_entry());
        start <= 1'b0;

        // Drain outstanding results, then let any trailing work settle
        settle = 0;
        while (pending != 0 && settle < 5000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (40) @(posedge clk);
        if (pending != 0)
            $error("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("[deadline_ordered_priority_queue_unit] OK");
        else
            $display("[deadline_ordered_priority_queue_unit] ERROR");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #1000000;
        $display("[deadline_ordered_priority_queue_unit] ERROR");
        $finish;
    end

endmodule

### filelist.f
sv/dopq_pkg.sv
sv/dopq_ram.sv
sv/dopq_key_cmp.sv
sv/deadline_ordered_priority_queue_unit.sv
tb/dopq_order_checker.sv
tb/tb.sv
